@@ src/srec_s3_record_encoder_unit_assert.svh @@
// Assertion macros shared by the S3 record encoder checker.
`ifndef SREC_S3_RECORD_ENCODER_UNIT_ASSERT_SVH
`define SREC_S3_RECORD_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SREC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srec encoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SREC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srec encoder assertion failed");

`endif

@@ src/srec_pkg.sv @@
// Types, codes and helpers shared by the S3 record encoder modules.
package srec_pkg;

    typedef logic [2:0] sel_t;

    localparam sel_t SEL_S3   = 3'd0;
    localparam sel_t SEL_CNT  = 3'd1;
    localparam sel_t SEL_ADDR = 3'd2;
    localparam sel_t SEL_DATA = 3'd3;
    localparam sel_t SEL_CSUM = 3'd4;
    localparam sel_t SEL_NL   = 3'd5;

    localparam logic [6:0] CHAR_S  = 7'h53;
    localparam logic [6:0] CHAR_3  = 7'h33;
    localparam logic [6:0] CHAR_NL = 7'h0A;

    typedef struct packed {
        logic load;
        logic emit;
        sel_t sel;
    } srec_cmd_t;

    typedef struct packed {
        logic flush;
        logic addr_last;
        logic data_last;
        logic out_free;
    } srec_status_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 7'h30 + {3'b000, nib};
        end
        return 7'h37 + {3'b000, nib};
    endfunction

endpackage

@@ src/srec_ctrl.sv @@
// Sequencer that walks the fields of one S3 record and gates input words.
module srec_ctrl
    import srec_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  srec_status_t status,
    output srec_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_CNT  = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_CSUM = 3'd5;
    localparam logic [2:0] ST_NL   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_S3;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid && status.flush) begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                cmd.sel  = SEL_S3;
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_CNT;
                end
            end
            ST_CNT: begin
                cmd.sel  = SEL_CNT;
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.sel  = SEL_ADDR;
                cmd.emit = status.out_free;
                if (status.out_free && status.addr_last) begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                cmd.sel  = SEL_DATA;
                cmd.emit = status.out_free;
                if (status.out_free && status.data_last) begin
                    state_next = ST_CSUM;
                end
            end
            ST_CSUM: begin
                cmd.sel  = SEL_CSUM;
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_NL;
                end
            end
            ST_NL: begin
                cmd.sel  = SEL_NL;
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/srec_dp.sv @@
// Byte buffer, address and checksum registers, and the output word register.
module srec_dp
    import srec_pkg::*;
#(
    parameter int RECORD_BYTES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [7:0]   data_byte,
    input  logic         segment_start,
    input  logic [31:0]  start_address,
    input  logic         segment_end,
    input  srec_cmd_t    cmd,
    output srec_status_t status,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [6:0]   first_char,
    output logic [6:0]   second_char,
    output logic         pair_valid,
    output logic         record_last
);

    localparam int FW = $clog2(RECORD_BYTES + 1);
    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam logic [FW-1:0] FULL = FW'(RECORD_BYTES);

    logic [7:0]    mem [RECORD_BYTES];
    logic [7:0]    rd_data_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] rd_idx_reg;
    logic [FW-1:0] rd_idx_next;
    logic [1:0]    ab_reg;
    logic [31:0]   addr_reg;
    logic [7:0]    sum_reg;
    logic [FW-1:0] wr_pos;
    logic [FW-1:0] wr_inc;
    logic [7:0]    count8;
    logic [7:0]    addr_byte;
    logic [7:0]    field_byte;
    logic          m_tvalid_reg;
    logic [6:0]    first_reg;
    logic [6:0]    second_reg;
    logic          pair_reg;
    logic          last_reg;

    assign wr_pos = (segment_start || fill_reg >= FULL) ? '0 : fill_reg;
    assign wr_inc = wr_pos + 1'b1;
    assign count8 = 8'(fill_reg) + 8'd5;
    assign addr_byte = 8'(addr_reg >> {~ab_reg, 3'b000});

    assign status.flush     = (wr_inc == FULL) || segment_end;
    assign status.addr_last = (ab_reg == 2'd3);
    assign status.data_last = (rd_idx_reg == fill_reg - 1'b1);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (cmd.sel)
            SEL_CNT:  field_byte = count8;
            SEL_ADDR: field_byte = addr_byte;
            SEL_DATA: field_byte = rd_data_reg;
            SEL_CSUM: field_byte = ~sum_reg;
            default:  field_byte = 8'h00;
        endcase
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.emit && cmd.sel == SEL_S3) begin
            rd_idx_next = '0;
        end else if (cmd.emit && cmd.sel == SEL_DATA) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.load) begin
            fill_next = wr_inc;
        end else if (cmd.emit && cmd.sel == SEL_NL) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[wr_pos[AW-1:0]] <= data_byte;
        end
        rd_data_reg <= mem[rd_idx_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            addr_reg   <= '0;
            rd_idx_reg <= '0;
            ab_reg     <= '0;
        end else begin
            fill_reg   <= fill_next;
            rd_idx_reg <= rd_idx_next;
            if (cmd.load && segment_start) begin
                addr_reg <= start_address;
            end else if (cmd.emit && cmd.sel == SEL_NL) begin
                addr_reg <= addr_reg + 32'(fill_reg);
            end
            if (cmd.emit && cmd.sel == SEL_S3) begin
                ab_reg <= '0;
            end else if (cmd.emit && cmd.sel == SEL_ADDR) begin
                ab_reg <= ab_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit && cmd.sel == SEL_S3) begin
            sum_reg <= count8;
        end else if (cmd.emit && (cmd.sel == SEL_ADDR || cmd.sel == SEL_DATA)) begin
            sum_reg <= sum_reg + field_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (cmd.sel == SEL_S3) begin
                first_reg  <= CHAR_S;
                second_reg <= CHAR_3;
                pair_reg   <= 1'b1;
                last_reg   <= 1'b0;
            end else if (cmd.sel == SEL_NL) begin
                first_reg  <= CHAR_NL;
                second_reg <= 7'h00;
                pair_reg   <= 1'b0;
                last_reg   <= 1'b1;
            end else begin
                first_reg  <= hex_char(field_byte[7:4]);
                second_reg <= hex_char(field_byte[3:0]);
                pair_reg   <= 1'b1;
                last_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign first_char  = first_reg;
    assign second_char = second_reg;
    assign pair_valid  = pair_reg;
    assign record_last = last_reg;

endmodule

@@ src/srec_s3_record_encoder_unit.sv @@
// Top level of the S3 record encoder: streams segment bytes in, ASCII pairs out.
//
// The slave channel takes one segment byte per word, with the load address
// beside it. tuser marks the first byte of a segment, which loads the record
// address; tlast marks its last byte and flushes the buffered bytes.
// The master channel gives one word per two ASCII characters: "S3", the
// count, four address bytes, the data bytes and the checksum, then a lone
// newline word with tlast high that ends the record.
// A byte that does not close a record is taken while the sequencer is idle.
// A byte that closes a record of n bytes stops the slave channel while the
// sequencer emits the n + 8 words of the record into the output register,
// one word per cycle whenever that register is free, starting with "S3".
// No new byte is taken until the newline word has been emitted.
// When the receiver stalls, the output register holds its word and the
// sequencer waits, so no word is lost. Reset clears the buffer fill, the
// record address and the output valid; buffer contents need no clearing.
module srec_s3_record_encoder_unit
    import srec_pkg::*;
#(
    parameter int RECORD_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], start_address [39:8]
    input  logic        s_tuser,   // segment_start
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // first_char [6:0], second_char [13:7], zero [15:14]
    output logic        m_tuser,   // pair_valid
    output logic        m_tlast
);

    srec_cmd_t    cmd;
    srec_status_t status;
    logic [6:0]   first_char;
    logic [6:0]   second_char;

    srec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srec_dp #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .data_byte     (s_tdata[7:0]),
        .segment_start (s_tuser),
        .start_address (s_tdata[39:8]),
        .segment_end   (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .first_char    (first_char),
        .second_char   (second_char),
        .pair_valid    (m_tuser),
        .record_last   (m_tlast)
    );

    assign m_tdata = {2'b00, second_char, first_char};

endmodule

@@ src/srec_chk.sv @@
// Port-level checker for the S3 record encoder and its bind statement.
`include "srec_s3_record_encoder_unit_assert.svh"

module srec_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `SREC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `SREC_ASSERT_SAME(a_last_is_newline, aclk, aresetn, m_tvalid && m_tlast, !m_tuser && m_tdata[6:0] == 7'h0A && m_tdata[13:7] == 7'h00)
    `SREC_ASSERT_SAME(a_lone_is_last, aclk, aresetn, m_tvalid && !m_tuser, m_tlast)
    `SREC_ASSERT_NEXT(a_flush_blocks_input, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind srec_s3_record_encoder_unit srec_chk u_srec_chk (.*);
